// ----- sv/sph_pkg.sv -----
`default_nettype none

package sph_pkg;

    // default geometry
    localparam int SPH_FIELD_SIDE    = 32;
    localparam int SPH_POS_FRAC_BITS = 24;

    // fixed field widths
    localparam int STICK_W   = 8;
    localparam int HEADING_W = 4;
    localparam int CELL_W    = 10;
    localparam int DZ_W      = 7;
    localparam int STEP_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = STEP_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REST_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Z      = 2'd2;

    // register reset values
    localparam logic [DZ_W-1:0]   REST_RADIUS_RST = 7'd14;
    localparam logic [STEP_W-1:0] STEP_X_RST      = 16'd1818;
    localparam logic [STEP_W-1:0] STEP_Z_RST      = 16'd2397;

    // heading codes
    localparam logic [HEADING_W-1:0] HDG_EAST  = 4'd0;
    localparam logic [HEADING_W-1:0] HDG_NE    = 4'd1;
    localparam logic [HEADING_W-1:0] HDG_NORTH = 4'd2;
    localparam logic [HEADING_W-1:0] HDG_NW    = 4'd3;
    localparam logic [HEADING_W-1:0] HDG_WEST  = 4'd4;
    localparam logic [HEADING_W-1:0] HDG_SW    = 4'd5;
    localparam logic [HEADING_W-1:0] HDG_SOUTH = 4'd6;
    localparam logic [HEADING_W-1:0] HDG_SE    = 4'd7;
    localparam logic [HEADING_W-1:0] HDG_STILL = 4'd8;

    // controller to datapath
    typedef struct packed {
        logic capture;   // take the sample, form offsets and products
        logic update;    // add, clamp and store the position
        logic scale;     // scale the position onto the grid
        logic load;      // fill the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being taken
    } t_sts;

endpackage

`default_nettype wire

// ----- sv/sph_in_if.sv -----
`default_nettype none

interface sph_in_if import sph_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STICK_W-1:0] stick_x;
    logic [STICK_W-1:0] stick_y;

    modport source (output valid, output stick_x, output stick_y, input ready);
    modport sink   (input valid, input stick_x, input stick_y, output ready);
endinterface

`default_nettype wire

// ----- sv/sph_out_if.sv -----
`default_nettype none

interface sph_out_if import sph_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STICK_W-1:0]   raw_x;
    logic [STICK_W-1:0]   raw_y;
    logic [HEADING_W-1:0] heading;
    logic [CELL_W-1:0]    cell_index;
    logic                 walled;
    logic                 moving;

    modport source (output valid, output raw_x, output raw_y, output heading,
                    output cell_index, output walled, output moving, input ready);
    modport sink   (input valid, input raw_x, input raw_y, input heading,
                    input cell_index, input walled, input moving, output ready);
endinterface

`default_nettype wire

// ----- sv/sph_ctrl.sv -----
`default_nettype none

module sph_ctrl import sph_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_UPD  = 4'b0010,
        ST_CELL = 4'b0100,
        ST_LOAD = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // sequencing: one sample at a time through add, scale and load
    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = ST_CELL;
            end
            ST_CELL: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_LOAD;
            end
            ST_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- sv/sph_dp.sv -----
`default_nettype none

module sph_dp import sph_pkg::*; #(
    parameter int FIELD_SIDE    = SPH_FIELD_SIDE,
    parameter int POS_FRAC_BITS = SPH_POS_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [STICK_W-1:0]    i_stick_x,
    input  wire logic [STICK_W-1:0]    i_stick_y,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [STICK_W-1:0]         o_raw_x,
    output logic [STICK_W-1:0]         o_raw_y,
    output logic [HEADING_W-1:0]       o_heading,
    output logic [CELL_W-1:0]          o_cell_index,
    output logic                       o_walled,
    output logic                       o_moving
);

    localparam int POS_W  = POS_FRAC_BITS + 1;
    localparam int PROD_W = STICK_W + STEP_W + 1;
    localparam int SUM_W  = ((POS_W > PROD_W) ? POS_W : PROD_W) + 2;
    localparam int CW     = $clog2(FIELD_SIDE);
    localparam int GM_W   = POS_W + CW + 1;
    localparam int IDX_W  = (2 * CW > CELL_W) ? 2 * CW : CELL_W;

    localparam logic [POS_W-1:0] POS_HALF = POS_W'(1) << (POS_FRAC_BITS - 1);
    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1) << POS_FRAC_BITS;
    localparam logic [SUM_W-1:0] SUM_ONE  = SUM_W'(1) << POS_FRAC_BITS;
    localparam logic [CW-1:0]    SIDE_M1  = CW'(FIELD_SIDE - 1);
    localparam logic [IDX_W-1:0] SIDE_W   = IDX_W'(FIELD_SIDE);

    // 8-way sector of a movement, 5/12 standing in for tan 22.5
    function automatic logic [HEADING_W-1:0] f_sector(
        input logic signed [STICK_W-1:0] mx,
        input logic signed [STICK_W-1:0] my
    );
        logic [STICK_W-1:0] ax;
        logic [STICK_W-1:0] ay;
        logic [10:0]        ax5;
        logic [10:0]        ay12;
        logic [10:0]        ax12;
        logic [10:0]        ay5;
        logic [HEADING_W-1:0] hdg;
        ax   = mx[STICK_W-1] ? STICK_W'(-mx) : STICK_W'(mx);
        ay   = my[STICK_W-1] ? STICK_W'(-my) : STICK_W'(my);
        ax5  = {3'b000, ax} * 11'd5;
        ay5  = {3'b000, ay} * 11'd5;
        ax12 = {3'b000, ax} * 11'd12;
        ay12 = {3'b000, ay} * 11'd12;
        if (ay12 < ax5) begin
            hdg = (mx > 0) ? HDG_EAST : HDG_WEST;
        end else if (ax12 < ay5) begin
            hdg = (my > 0) ? HDG_NORTH : HDG_SOUTH;
        end else if (mx > 0) begin
            hdg = (my > 0) ? HDG_NE : HDG_SE;
        end else begin
            hdg = (my > 0) ? HDG_NW : HDG_SW;
        end
        return hdg;
    endfunction

    // configuration registers
    logic [DZ_W-1:0]   r_rest_radius;
    logic [STEP_W-1:0] r_step_x;
    logic [STEP_W-1:0] r_step_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rest_radius <= REST_RADIUS_RST;
            r_step_x      <= STEP_X_RST;
            r_step_z      <= STEP_Z_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REST_RADIUS: r_rest_radius <= i_cfg_data[DZ_W-1:0];
                CFG_STEP_X:      r_step_x      <= i_cfg_data;
                CFG_STEP_Z:      r_step_z      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // capture: centred offsets, dead zone test, position increments
    logic signed [STICK_W-1:0] dx;
    logic signed [STICK_W-1:0] dy;
    logic signed [15:0]        sq_x;
    logic signed [15:0]        sq_y;
    logic [16:0]               sq_sum;
    logic [13:0]               dz_sq;
    logic signed [PROD_W-1:0]  n_prod_x;
    logic signed [PROD_W-1:0]  n_prod_z;

    assign dx = {~i_stick_x[STICK_W-1], i_stick_x[STICK_W-2:0]};
    assign dy = {~i_stick_y[STICK_W-1], i_stick_y[STICK_W-2:0]};

    always_comb begin
        sq_x     = dx * dx;
        sq_y     = dy * dy;
        sq_sum   = {1'b0, sq_x} + {1'b0, sq_y};
        dz_sq    = {7'd0, r_rest_radius} * {7'd0, r_rest_radius};
        n_prod_x = dx * $signed({1'b0, r_step_x});
        n_prod_z = dy * $signed({1'b0, r_step_z});
    end

    logic [STICK_W-1:0]        r_raw_x;
    logic [STICK_W-1:0]        r_raw_y;
    logic signed [STICK_W-1:0] r_dx;
    logic signed [STICK_W-1:0] r_dy;
    logic                      r_moving;
    logic signed [PROD_W-1:0]  r_prod_x;
    logic signed [PROD_W-1:0]  r_prod_z;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_raw_x  <= i_stick_x;
            r_raw_y  <= i_stick_y;
            r_dx     <= dx;
            r_dy     <= dy;
            r_moving <= sq_sum > {3'b000, dz_sq};
            r_prod_x <= n_prod_x;
            r_prod_z <= n_prod_z;
        end
    end

    // update: unclamped position, clamp to the unit square
    logic signed [SUM_W-1:0] ux;
    logic signed [SUM_W-1:0] uz;
    logic [POS_W-1:0]        nx;
    logic [POS_W-1:0]        nz;
    logic                    clip_x;
    logic                    clip_z;
    logic [POS_W-1:0]        r_pos_x;
    logic [POS_W-1:0]        r_pos_z;
    logic                    r_chg_x;
    logic                    r_chg_z;
    logic                    r_walled;

    always_comb begin
        ux     = $signed(SUM_W'(r_pos_x)) + SUM_W'(r_prod_x);
        uz     = $signed(SUM_W'(r_pos_z)) - SUM_W'(r_prod_z);
        clip_x = 1'b1;
        clip_z = 1'b1;
        if (ux < 0) begin
            nx = '0;
        end else if (ux > $signed(SUM_ONE)) begin
            nx = POS_ONE;
        end else begin
            nx     = ux[POS_W-1:0];
            clip_x = 1'b0;
        end
        if (uz < 0) begin
            nz = '0;
        end else if (uz > $signed(SUM_ONE)) begin
            nz = POS_ONE;
        end else begin
            nz     = uz[POS_W-1:0];
            clip_z = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= POS_HALF;
            r_pos_z <= POS_HALF;
        end else if (i_cmd.update && r_moving) begin
            r_pos_x <= nx;
            r_pos_z <= nz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_chg_x  <= r_moving && (nx != r_pos_x);
            r_chg_z  <= r_moving && (nz != r_pos_z);
            r_walled <= r_moving && (clip_x || clip_z);
        end
    end

    // grid scaling, round half up
    logic [GM_W-1:0] gm_x;
    logic [GM_W-1:0] gm_z;
    logic [CW-1:0]   r_fx;
    logic [CW-1:0]   r_fz;

    always_comb begin
        gm_x = GM_W'(r_pos_x) * GM_W'(SIDE_M1) + GM_W'(POS_HALF);
        gm_z = GM_W'(r_pos_z) * GM_W'(SIDE_M1) + GM_W'(POS_HALF);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_fx <= gm_x[POS_FRAC_BITS +: CW];
            r_fz <= gm_z[POS_FRAC_BITS +: CW];
        end
    end

    // load: heading from the surviving movement, cell index
    logic signed [STICK_W-1:0] mx;
    logic signed [STICK_W-1:0] my;
    logic [HEADING_W-1:0]      n_heading;
    logic [IDX_W-1:0]          n_idx;

    always_comb begin
        mx        = r_chg_x ? r_dx : '0;
        my        = r_chg_z ? r_dy : '0;
        n_heading = (r_chg_x || r_chg_z) ? f_sector(mx, my) : HDG_STILL;
        n_idx     = IDX_W'(r_fz) * SIDE_W + IDX_W'(r_fx);
    end

    // output register
    logic r_out_valid;

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_raw_x      <= r_raw_x;
            o_raw_y      <= r_raw_y;
            o_heading    <= n_heading;
            o_cell_index <= n_idx[CELL_W-1:0];
            o_walled     <= r_walled;
            o_moving     <= r_moving;
        end
    end

endmodule

`default_nettype wire

// ----- sv/stick_position_heading_tracker.sv -----
// Channel  Direction  Transfer when       Payload
// i_in     in         valid & ready       stick_x, stick_y
// o_out    out        valid & ready       raw_x, raw_y, heading, cell_index, walled, moving
// i_cfg    in         i_cfg_we            i_cfg_idx, i_cfg_data (no read-back)
//
// A sample goes through these steps in order: transfer (offsets and gain products),
// position add and clamp, grid scaling, output load. The controller handles
// one sample at a time and takes no new sample until the last one is loaded.
// Reset (synchronous) centres the position and loads the register defaults.
// A result waiting in the output register holds the controller at the load
// step; no new sample is taken until that result has been loaded.
`default_nettype none

module stick_position_heading_tracker import sph_pkg::*; #(
    parameter int FIELD_SIDE    = SPH_FIELD_SIDE,
    parameter int POS_FRAC_BITS = SPH_POS_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    sph_in_if.sink                     i_in,
    sph_out_if.source                  o_out
);

    t_cmd cmd;
    t_sts sts;

    sph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sph_dp #(
        .FIELD_SIDE    (FIELD_SIDE),
        .POS_FRAC_BITS (POS_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_stick_x    (i_in.stick_x),
        .i_stick_y    (i_in.stick_y),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (o_out.ready),
        .o_out_valid  (o_out.valid),
        .o_raw_x      (o_out.raw_x),
        .o_raw_y      (o_out.raw_y),
        .o_heading    (o_out.heading),
        .o_cell_index (o_out.cell_index),
        .o_walled     (o_out.walled),
        .o_moving     (o_out.moving)
    );

endmodule

`default_nettype wire

// ----- sv/sph_checker.sv -----
`default_nettype none

module sph_checker import sph_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_out_valid,
    input wire logic                 i_out_ready,
    input wire logic [HEADING_W-1:0] i_heading,
    input wire logic                 i_walled,
    input wire logic                 i_moving
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // heading code is a sector or still
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_heading <= HDG_STILL)
        else $error("heading code out of range");

    // a stick in the dead zone neither turns nor hits a wall
    a_still_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_moving |-> i_heading == HDG_STILL && !i_walled)
        else $error("still sample reported movement");

    // a real heading needs the stick outside the dead zone
    a_heading_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_heading != HDG_STILL |-> i_moving)
        else $error("heading without movement");

endmodule

bind stick_position_heading_tracker sph_checker u_sph_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_heading   (o_out.heading),
    .i_walled    (o_out.walled),
    .i_moving    (o_out.moving)
);

`default_nettype wire

// ----- bench/heading_tracker_check.sv -----
// Watches the sample and result channels and the register write port, keeps
// its own copy of the tracker's position and registers, and checks every
// result transfer against the oldest outstanding prediction.
module heading_tracker_check import sph_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    sph_in_if                          i_samples,
    sph_out_if                         i_results,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     POS_W        = SPH_POS_FRAC_BITS + 1;
    localparam longint POS_ONE      = longint'(1) << SPH_POS_FRAC_BITS;
    localparam longint POS_HALF     = longint'(1) << (SPH_POS_FRAC_BITS - 1);
    localparam int     STICK_CENTRE = 128;
    // 5/12 approximates tan 22.5 deg
    localparam int     TAN_NUM      = 5;
    localparam int     TAN_DEN      = 12;

    typedef struct packed {
        logic [STICK_W-1:0]   raw_x;
        logic [STICK_W-1:0]   raw_y;
        logic [HEADING_W-1:0] heading;
        logic [CELL_W-1:0]    cell_index;
        logic                 walled;
        logic                 moving;
    } t_track_result;

    logic [DZ_W-1:0]   rest_radius;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_z;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_z;

    t_track_result expected_results[$];
    int            mismatches = 0;

    // eight 45 deg sectors, counterclockwise from east
    function automatic logic [HEADING_W-1:0] sector_of(input int mx, input int my);
        int ax, ay;
        ax = (mx < 0) ? -mx : mx;
        ay = (my < 0) ? -my : my;
        if (ay * TAN_DEN < ax * TAN_NUM) return (mx > 0) ? HDG_EAST : HDG_WEST;
        if (ax * TAN_DEN < ay * TAN_NUM) return (my > 0) ? HDG_NORTH : HDG_SOUTH;
        if (mx > 0) return (my > 0) ? HDG_NE : HDG_SE;
        return (my > 0) ? HDG_NW : HDG_SW;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v < 0) return 0;
        if (v > POS_ONE) return POS_ONE;
        return v;
    endfunction

    // grid cell of the position, rounded half up, low bits only
    function automatic logic [CELL_W-1:0] cell_of(input logic [POS_W-1:0] px,
                                                  input logic [POS_W-1:0] pz);
        longint fx, fz;
        fx = (longint'(px) * (SPH_FIELD_SIDE - 1) + POS_HALF) >> SPH_POS_FRAC_BITS;
        fz = (longint'(pz) * (SPH_FIELD_SIDE - 1) + POS_HALF) >> SPH_POS_FRAC_BITS;
        return CELL_W'(fz * SPH_FIELD_SIDE + fx);
    endfunction

    // moves the tracked position by one stick sample and forms its result
    function automatic t_track_result advance_position(input logic [STICK_W-1:0] sx,
                                                       input logic [STICK_W-1:0] sy);
        t_track_result r;
        int            dx, dy, mx, my;
        longint        ux, uz, nx, nz;
        dx = int'(sx) - STICK_CENTRE;
        dy = int'(sy) - STICK_CENTRE;
        r.raw_x   = sx;
        r.raw_y   = sy;
        r.heading = HDG_STILL;
        r.walled  = 1'b0;
        r.moving  = (dx * dx + dy * dy) > int'(rest_radius) * int'(rest_radius);
        if (r.moving) begin
            ux = longint'(pos_x) + longint'(dx) * longint'(step_x);
            uz = longint'(pos_z) - longint'(dy) * longint'(step_z);
            nx = clamp_unit(ux);
            nz = clamp_unit(uz);
            // an axis that could not move counts as zero for the heading
            mx = (nx != longint'(pos_x)) ? dx : 0;
            my = (nz != longint'(pos_z)) ? dy : 0;
            r.walled = (nx != ux) || (nz != uz);
            pos_x = POS_W'(nx);
            pos_z = POS_W'(nz);
            if (mx != 0 || my != 0) r.heading = sector_of(mx, my);
        end
        r.cell_index = cell_of(pos_x, pos_z);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_track_result want;
        if (!i_rst_n) begin
            rest_radius = REST_RADIUS_RST;
            step_x      = STEP_X_RST;
            step_z      = STEP_Z_RST;
            pos_x       = POS_W'(POS_HALF);
            pos_z       = POS_W'(POS_HALF);
            expected_results.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_REST_RADIUS: rest_radius = i_cfg_data[DZ_W-1:0];
                    CFG_STEP_X:      step_x      = i_cfg_data[STEP_W-1:0];
                    CFG_STEP_Z:      step_z      = i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            // result transfer: compare against the oldest prediction first
            if (i_results.valid && i_results.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no prediction outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("raw_x",      32'(want.raw_x),      32'(i_results.raw_x));
                    check_field("raw_y",      32'(want.raw_y),      32'(i_results.raw_y));
                    check_field("heading",    32'(want.heading),    32'(i_results.heading));
                    check_field("cell_index", 32'(want.cell_index),
                                32'(i_results.cell_index));
                    check_field("walled",     32'(want.walled),     32'(i_results.walled));
                    check_field("moving",     32'(want.moving),     32'(i_results.moving));
                end
            end
            // sample transfer
            if (i_samples.valid && i_samples.ready)
                expected_results.push_back(advance_position(i_samples.stick_x,
                                                            i_samples.stick_y));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- bench/tb.sv -----
module tb import sph_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT         = 18;
    localparam int RANDOM_PHASES    = 7;
    localparam int SAMPLES_PER_PHASE = 150;
    localparam int CALM_PHASE       = 3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    calm;
    int                    fail_count;
    int                    pending;

    sph_in_if  samples();
    sph_out_if results();

    stick_position_heading_tracker dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (samples),
        .o_out      (results)
    );

    heading_tracker_check checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_samples    (samples),
        .i_results    (results),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // directed samples, {stick_x, stick_y}
    // default registers: centre, dead zone rim either side, then all eight sectors
    logic [15:0] sector_probes [11] = '{16'h8080, 16'h8E80, 16'h8F80, 16'hFF80,
                                        16'hFFFF, 16'h80FF, 16'h00FF, 16'h0080,
                                        16'h0000, 16'h8000, 16'hFF00};
    // zero dead zone, full steps: clamp, fully walled, one axis stopped
    logic [15:0] wall_probes [11] = '{16'h8080, 16'h8180, 16'hFF80, 16'hFF80,
                                      16'hFF80, 16'hFF00, 16'hFF00, 16'h00FF,
                                      16'h00FF, 16'h00FF, 16'h40C0};
    // widest dead zone, zero steps: moving but going nowhere
    logic [15:0] frozen_probes [3] = '{16'hFFFF, 16'h0000, 16'h8000};

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end

    // result side back-pressure
    initial begin
        results.ready = 1'b0;
        forever begin
            @(posedge clk);
            results.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic [7:0] rim_byte();
        case ($urandom_range(4))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd128;
            3:       return 8'd1;
            default: return 8'd254;
        endcase
    endfunction

    // mostly anywhere, some around the dead zone rim, some at the extremes
    function automatic logic [15:0] pick_stick(input int dz);
        int         off;
        logic [7:0] a, b;
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return 16'($urandom);
            6, 7: begin
                off = dz - 1 + $urandom_range(2);
                if (off < 0) off = 0;
                if (off > 127) off = 127;
                a = $urandom_range(1) ? 8'(128 + off) : 8'(128 - off);
                b = 8'(127 + $urandom_range(2));
                return $urandom_range(1) ? {a, b} : {b, a};
            end
            default: begin
                a = rim_byte();
                b = rim_byte();
                return {a, b};
            end
        endcase
    endfunction

    // one sample transfer; valid stays up for the caller to reuse or drop
    task automatic send_sample(input logic [15:0] stick);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                samples.valid <= 1'b0;
                @(posedge clk);
            end
        end
        samples.valid   <= 1'b1;
        samples.stick_x <= stick[15:8];
        samples.stick_y <= stick[7:0];
        @(posedge clk);
        while (!samples.ready) @(posedge clk);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_tracker();
        samples.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic load_settings(input logic [DZ_W-1:0] dz, input logic [STEP_W-1:0] sx,
                                 input logic [STEP_W-1:0] sz);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_REST_RADIUS;
        cfg_data <= CFG_DATA_W'(dz);
        @(posedge clk);
        cfg_idx  <= CFG_STEP_X;
        cfg_data <= sx;
        @(posedge clk);
        cfg_idx  <= CFG_STEP_Z;
        cfg_data <= sz;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [DZ_W-1:0]   dz_set;
        logic [STEP_W-1:0] sx_set, sz_set;
        logic [15:0]       stick;
        int                sent, run;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_idx         = CFG_REST_RADIUS;
        cfg_data        = '0;
        calm            = 1'b0;
        samples.valid   = 1'b0;
        samples.stick_x = '0;
        samples.stick_y = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset registers first
        foreach (sector_probes[i]) send_sample(sector_probes[i]);
        drain_tracker();
        load_settings(DZ_W'(0), 16'hFFFF, 16'hFFFF);
        foreach (wall_probes[i]) send_sample(wall_probes[i]);
        drain_tracker();
        load_settings(DZ_W'(127), 16'h0000, 16'h0000);
        foreach (frozen_probes[i]) send_sample(frozen_probes[i]);

        // random part, a fresh register setting per phase
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin dz_set = 7'd0;   sx_set = 16'hFFFF; sz_set = 16'hFFFF; end
                1: begin dz_set = 7'd127; sx_set = 16'($urandom); sz_set = 16'($urandom); end
                2: begin dz_set = REST_RADIUS_RST; sx_set = STEP_X_RST; sz_set = STEP_Z_RST; end
                4: begin
                    dz_set = 7'($urandom_range(30));
                    sx_set = 16'h0000;
                    sz_set = 16'($urandom);
                end
                6: begin dz_set = 7'd1; sx_set = 16'd1; sz_set = 16'($urandom_range(4000)); end
                default: begin
                    dz_set = 7'($urandom_range(40));
                    sx_set = 16'($urandom);
                    sz_set = 16'($urandom_range(8000));
                end
            endcase
            drain_tracker();
            load_settings(dz_set, sx_set, sz_set);
            calm = (phase == CALM_PHASE);
            sent = 0;
            while (sent < SAMPLES_PER_PHASE) begin
                stick = pick_stick(int'(dz_set));
                // now and then hold the stick to push into a wall
                run = ($urandom_range(9) == 0) ? $urandom_range(20, 5) : 1;
                repeat (run) begin
                    send_sample(stick);
                    sent++;
                end
            end
        end
        calm = 1'b0;

        drain_tracker();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/sph_pkg.sv
sv/sph_in_if.sv
sv/sph_out_if.sv
sv/sph_ctrl.sv
sv/sph_dp.sv
sv/stick_position_heading_tracker.sv
sv/sph_checker.sv
bench/heading_tracker_check.sv
bench/tb.sv
